// ===== src/tpfd_pkg.sv =====
// ----------------------------------------------------------------------------
// tpfd_pkg
// Shared types, codes and constants for the tuner PLL frame decoder.
// ----------------------------------------------------------------------------
package tpfd_pkg;

	// frame byte codes
	localparam logic [7:0] CTRL_FM       = 8'h54;
	localparam logic [7:0] CTRL_MW       = 8'h19;
	localparam logic [7:0] CTRL_LW       = 8'h1D;
	localparam logic [7:0] CTRL_PERSIST  = 8'h88;
	localparam logic [7:0] CTRL_TRANS    = 8'h98;
	localparam logic [7:0] LEAD_TRANS    = 8'hEB;
	localparam logic [7:0] LEAD_ANY_BAND = 8'hE3;
	localparam logic [7:0] LEAD_MW       = 8'hEF;
	localparam logic [7:0] LEAD_LW       = 8'hED;
	localparam logic [7:0] SEL_FM_A      = 8'h4C;
	localparam logic [7:0] SEL_FM_B      = 8'hCC;
	localparam logic [7:0] SEL_MW        = 8'h4D;
	localparam logic [7:0] SEL_LW        = 8'h4F;

	// scaling constants
	localparam logic [15:0] STEP_FM      = 16'd50000;
	localparam logic [15:0] STEP_MW      = 16'd1125;
	localparam logic [15:0] STEP_LW      = 16'd125;
	localparam logic [31:0] IF_FM        = 32'd10700000;
	localparam logic [27:0] IF_AM        = 28'd450000;
	// FM band 76..108 MHz after the IF offset, as PLL counts
	localparam logic [15:0] FM_COUNT_MIN = 16'd1734;
	localparam logic [15:0] FM_COUNT_MAX = 16'd2374;

	typedef enum logic [1:0] {
		KIND_UNKNOWN = 2'd0,
		KIND_FREQ    = 2'd1,
		KIND_PERSIST = 2'd2,
		KIND_TRANS   = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		BAND_NONE = 2'd0,
		BAND_FM   = 2'd1,
		BAND_MW   = 2'd2,
		BAND_LW   = 2'd3
	} band_t;

	typedef enum logic [1:0] {
		ANT_NONE = 2'd0,
		ANT_A    = 2'd1,
		ANT_B    = 2'd2
	} ant_t;

	typedef struct packed {
		logic [7:0] first_byte;
		logic [7:0] second_byte;
		logic [7:0] third_byte;
	} frame_t;

	typedef struct packed {
		kind_t              frame_kind;
		band_t              band;
		ant_t               antenna;
		logic signed [27:0] tuned_hz;
	} result_t;

	// mirror the bit order of one byte
	function automatic logic [7:0] flip8(input logic [7:0] b);
		logic [7:0] r;
		for (int k = 0; k < 8; k++) begin
			r[7 - k] = b[k];
		end
		return r;
	endfunction

endpackage

// ===== src/tuner_pll_frame_decoder.sv =====
// ----------------------------------------------------------------------------
// tuner_pll_frame_decoder
// Decodes three-byte tuner PLL control frames into kind, band, antenna and
// tuned frequency in hertz.
// ----------------------------------------------------------------------------
// Usage:
//   A frame beat is taken on any clock edge with start high; busy stays low,
//   so a new frame may be offered every cycle.
//   Each frame gives exactly one result beat on the result port, marked by a
//   one-cycle done strobe, once the frame has passed the input register and
//   then the decode into the result register, both registers in that order.
//   Throughput is one frame per cycle, set by the single-pass decode with one
//   shared constant multiplier between the two registers.
//   The receiver cannot stall; every done beat must be captured when shown.
//   Reset (arst_n low) clears the pipeline valid flags, so no done strobe
//   follows reset until a new frame is taken. No configuration is held.
// ----------------------------------------------------------------------------
module tuner_pll_frame_decoder (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  tpfd_pkg::frame_t  frame,
	output logic              done,
	output tpfd_pkg::result_t result
);

	logic              valid_s1;
	tpfd_pkg::frame_t  frame_s1;
	logic              valid_s2;
	tpfd_pkg::result_t result_s2;
	tpfd_pkg::result_t decoded;

	assign busy = 1'b0;

	// input register: valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	// input register: frame beat
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			frame_s1 <= frame;
		end
	end

	tpfd_decode u_decode (
		.frame  (frame_s1),
		.result (decoded)
	);

	// result register: valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	// result register: decoded beat
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			result_s2 <= decoded;
		end
	end

	assign done   = valid_s2;
	assign result = result_s2;

endmodule

// ===== src/tpfd_decode.sv =====
// ----------------------------------------------------------------------------
// tpfd_decode
// Combinational decode of one registered frame into kind, band, antenna
// and tuned frequency.
// ----------------------------------------------------------------------------
module tpfd_decode (
	input  tpfd_pkg::frame_t  frame,
	output tpfd_pkg::result_t result
);

	logic [15:0] count;
	logic [15:0] step;
	logic [31:0] prod;
	logic [26:0] am_half;
	logic [27:0] fm_freq;
	logic [27:0] am_freq;
	logic        fm_in_band;

	// pll count, low byte first, each byte mirrored
	assign count = {tpfd_pkg::flip8(frame.second_byte), tpfd_pkg::flip8(frame.first_byte)};

	// one shared multiplier, step chosen by the control byte
	always_comb begin
		priority if (frame.third_byte == tpfd_pkg::CTRL_FM) begin
			step = tpfd_pkg::STEP_FM;
		end else if (frame.third_byte == tpfd_pkg::CTRL_MW) begin
			step = tpfd_pkg::STEP_MW;
		end else begin
			step = tpfd_pkg::STEP_LW;
		end
	end

	assign prod = 32'(count) * 32'(step);

	// fm: subtract if offset; am: half-hertz round up then subtract if
	assign fm_freq    = 28'(prod - tpfd_pkg::IF_FM);
	assign am_half    = 27'((28'(prod[26:0]) + 28'd1) >> 1);
	assign am_freq    = 28'(am_half) - tpfd_pkg::IF_AM;
	assign fm_in_band = (count >= tpfd_pkg::FM_COUNT_MIN) && (count <= tpfd_pkg::FM_COUNT_MAX);

	// frame classification in priority order
	always_comb begin
		result.frame_kind = tpfd_pkg::KIND_UNKNOWN;
		result.band       = tpfd_pkg::BAND_NONE;
		result.antenna    = tpfd_pkg::ANT_NONE;
		result.tuned_hz   = '0;
		priority if (frame.third_byte == tpfd_pkg::CTRL_FM) begin
			if (fm_in_band) begin
				result.frame_kind = tpfd_pkg::KIND_FREQ;
				result.band       = tpfd_pkg::BAND_FM;
				result.tuned_hz   = fm_freq;
			end
		end else if (frame.third_byte == tpfd_pkg::CTRL_MW) begin
			result.frame_kind = tpfd_pkg::KIND_FREQ;
			result.band       = tpfd_pkg::BAND_MW;
			result.tuned_hz   = am_freq;
		end else if (frame.third_byte == tpfd_pkg::CTRL_LW) begin
			result.frame_kind = tpfd_pkg::KIND_FREQ;
			result.band       = tpfd_pkg::BAND_LW;
			result.tuned_hz   = am_freq;
		end else if (frame.third_byte == tpfd_pkg::CTRL_PERSIST
				&& frame.first_byte == tpfd_pkg::LEAD_ANY_BAND
				&& frame.second_byte == tpfd_pkg::SEL_FM_A) begin
			result.frame_kind = tpfd_pkg::KIND_PERSIST;
			result.band       = tpfd_pkg::BAND_FM;
			result.antenna    = tpfd_pkg::ANT_A;
		end else if (frame.third_byte == tpfd_pkg::CTRL_PERSIST
				&& frame.first_byte == tpfd_pkg::LEAD_ANY_BAND
				&& frame.second_byte == tpfd_pkg::SEL_FM_B) begin
			result.frame_kind = tpfd_pkg::KIND_PERSIST;
			result.band       = tpfd_pkg::BAND_FM;
			result.antenna    = tpfd_pkg::ANT_B;
		end else if (frame.third_byte == tpfd_pkg::CTRL_PERSIST
				&& (frame.first_byte == tpfd_pkg::LEAD_ANY_BAND
				|| frame.first_byte == tpfd_pkg::LEAD_MW)
				&& frame.second_byte == tpfd_pkg::SEL_MW) begin
			result.frame_kind = tpfd_pkg::KIND_PERSIST;
			result.band       = tpfd_pkg::BAND_MW;
		end else if (frame.third_byte == tpfd_pkg::CTRL_PERSIST
				&& (frame.first_byte == tpfd_pkg::LEAD_ANY_BAND
				|| frame.first_byte == tpfd_pkg::LEAD_LW)
				&& frame.second_byte == tpfd_pkg::SEL_LW) begin
			result.frame_kind = tpfd_pkg::KIND_PERSIST;
			result.band       = tpfd_pkg::BAND_LW;
		end else if (frame.first_byte == tpfd_pkg::LEAD_TRANS
				|| frame.third_byte == tpfd_pkg::CTRL_TRANS) begin
			result.frame_kind = tpfd_pkg::KIND_TRANS;
		end else begin
			result.frame_kind = tpfd_pkg::KIND_UNKNOWN;
		end
	end

endmodule
